### rtl/ray_march_column_caster_unit_assert.svh
// Assertion macros used by the caster controller.
`ifndef RAY_MARCH_COLUMN_CASTER_UNIT_ASSERT_SVH
`define RAY_MARCH_COLUMN_CASTER_UNIT_ASSERT_SVH
// implication on one cycle
`define RMC_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// implication into the next cycle
`define RMC_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

### rtl/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Types, constants and functions of the ray-march column caster.
// ----------------------------------------------------------------------------
package rmc_pkg;
	localparam int DEF_MAP_COLUMNS    = 16;
	localparam int DEF_MAP_ROWS       = 16;
	localparam int DEF_TILE_PIXELS    = 64;
	localparam int DEF_SCREEN_COLUMNS = 640;
	localparam int DEF_SCREEN_ROWS    = 480;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	localparam logic [1:0] REG_MAX_STEPS = 2'd0;
	localparam logic [1:0] REG_STEP_LEN  = 2'd1;
	localparam logic [1:0] REG_FOV       = 2'd2;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_WALL = 2'd1;
	localparam logic [1:0] KIND_OUT  = 2'd2;

	typedef struct packed {
		logic        command;
		logic [7:0]  tile_address;
		logic        tile_is_wall;
		logic [17:0] viewer_x;
		logic [17:0] viewer_y;
		logic [9:0]  heading;
		logic [9:0]  screen_column;
	} in_req_t;

	typedef struct packed {
		logic [9:0] column_out;
		logic [8:0] strip_top;
		logic [8:0] strip_bottom;
		logic [1:0] hit_kind;
		logic [7:0] steps_taken;
	} out_req_t;

	typedef struct packed {
		logic [1:0] index;
		logic [8:0] data;
	} cfg_req_t;

	typedef struct packed {
		logic load;
		logic angle_go;
		logic sine_go;
		logic step;
		logic finish;
		logic div_go;
		logic result;
	} rmc_cmd_t;

	typedef struct packed {
		logic sine_done;
		logic march_done;
		logic div_done;
	} rmc_sts_t;
endpackage

### rtl/rmc_divider.sv
// ----------------------------------------------------------------------------
// rmc_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmc_divider import rmc_pkg::*; #(
	parameter int N = 64,
	parameter int D = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [N-1:0] num,
	input  logic [D-1:0] den,
	output logic         done,
	output logic [N-1:0] quo
);
	localparam int CW = $clog2(N + 1);
	logic [N-1:0] q_q;
	logic [D:0]   r_q;
	logic [D-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic         busy_q;
	logic [D:0]   trial;
	logic [D:0]   sub;

	assign trial = {r_q[D-1:0], q_q[N-1]};
	assign sub   = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q   <= num;
			r_q   <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!sub[D]) begin
				r_q <= sub;
				q_q <= {q_q[N-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[N-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule

### rtl/rmc_datapath.sv
// ----------------------------------------------------------------------------
// rmc_datapath
// Angle, sine/cosine, march stepping, wall map and strip height.
// ----------------------------------------------------------------------------
module rmc_datapath import rmc_pkg::*; #(
	parameter int MAP_COLUMNS    = DEF_MAP_COLUMNS,
	parameter int MAP_ROWS       = DEF_MAP_ROWS,
	parameter int TILE_PIXELS    = DEF_TILE_PIXELS,
	parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  rmc_cmd_t cmd,
	output rmc_sts_t sts,
	input  in_req_t  req,
	input  logic     cfg_we,
	input  cfg_req_t cfg,
	output out_req_t res
);
	localparam int PXW = 32;
	localparam logic signed [PXW-1:0] XLIM = PXW'(MAP_COLUMNS * TILE_PIXELS);
	localparam logic signed [PXW-1:0] YLIM = PXW'(MAP_ROWS * TILE_PIXELS);
	localparam int TP = TILE_PIXELS;
	localparam int MC = MAP_COLUMNS;
	localparam logic [63:0] COL_RCP = ((64'd1 << 37) + 64'(SCREEN_COLUMNS) - 64'd1)
		/ 64'(SCREEN_COLUMNS);
	localparam logic [1:0] PH_ADV  = 2'd0;
	localparam logic [1:0] PH_READ = 2'd1;
	localparam logic [1:0] PH_TEST = 2'd2;

	logic [7:0]  max_q, len_q;
	logic [8:0]  fov_q;
	logic        map_q [256];
	in_req_t     req_q;
	logic [15:0] angle_q;
	logic signed [15:0] sin_q, cos_q;
	logic [7:0]  n_q;
	logic [1:0]  kind_q;
	logic        done_q;
	logic [15:0] d_q;
	logic signed [47:0] ax_q, ay_q;
	logic        sine_done_q;
	logic        wall_rd_q;
	logic [7:0]  tidx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 8'd200;
			len_q <= 8'd26;
			fov_q <= 9'd171;
		end else if (cfg_we) begin
			unique case (cfg.index)
				REG_MAX_STEPS: max_q <= cfg.data[7:0];
				REG_STEP_LEN:  len_q <= cfg.data[7:0];
				REG_FOV:       fov_q <= cfg.data;
				default: ;
			endcase
		end
	end

	logic [255:0] valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (cmd.load && req.command == CMD_WRITE) valid_q[req.tile_address] <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (cmd.load && req.command == CMD_WRITE) map_q[req.tile_address] <= req.tile_is_wall;
		if (cmd.load) req_q <= req;
		wall_rd_q <= valid_q[tidx] && map_q[tidx];
	end

	// angle: product registered at load, then divide by constant
	logic [31:0] prod_q;
	logic [31:0] col_part;
	assign col_part = 32'((64'(prod_q) * COL_RCP) >> 31);
	always_ff @(posedge clk) begin
		if (cmd.load) prod_q <= 32'(req.screen_column) * 32'(fov_q);
		if (cmd.angle_go)
			angle_q <= 16'(32'(req_q.heading) * 32'd64 + col_part
				- 32'(fov_q) * 32'd32);
	end

	// sine: two sequential divisions (sin then cos)
	logic        sdiv_go, sdiv_done, sel_q;
	logic [47:0] snum, squo;
	logic [31:0] sden;
	logic [14:0] hh;
	logic [29:0] pp;
	logic [15:0] sang;
	assign sang = sel_q ? angle_q + 16'd16384 : angle_q;
	assign hh   = sang[14:0];
	assign pp   = 30'({15'd0, hh} * (30'd32768 - 30'(hh)));
	assign snum = {2'b0, pp, 16'd0};
	assign sden = (32'd5 << 28) - 32'(pp);
	logic sine_busy_q, sine_step_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0; sine_busy_q <= 1'b0; sine_step_q <= 1'b0; sine_done_q <= 1'b0;
		end else begin
			sine_step_q <= 1'b0;
			sine_done_q <= 1'b0;
			if (cmd.sine_go) begin
				sel_q <= 1'b0; sine_busy_q <= 1'b1; sine_step_q <= 1'b1;
			end else if (sine_busy_q && sdiv_done) begin
				if (!sel_q) begin
					sel_q <= 1'b1; sine_step_q <= 1'b1;
				end else begin
					sine_busy_q <= 1'b0; sine_done_q <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (sine_busy_q && sdiv_done) begin
			if (!sel_q) sin_q <= sang[15] ? -16'(squo) : 16'(squo);
			else        cos_q <= sang[15] ? -16'(squo) : 16'(squo);
		end
	end
	assign sdiv_go = sine_step_q;
	rmc_divider #(.N(48), .D(32)) u_sdiv (
		.clk(clk), .arst_n(arst_n), .go(sdiv_go), .num(snum), .den(sden),
		.done(sdiv_done), .quo(squo)
	);

	// march: accumulate position, each step in phases advance, read, test
	logic signed [31:0] px, py;
	logic signed [47:0] nx, ny;
	logic [1:0]  ph_q;
	assign nx = ax_q + 48'(cos_q) * 48'(len_q);
	assign ny = ay_q + 48'(sin_q) * 48'(len_q);
	function automatic logic signed [31:0] trunc22(input logic signed [47:0] v);
		logic [47:0] m;
		m = v[47] ? 48'(-v) : 48'(v);
		trunc22 = v[47] ? -32'(m >> 22) : 32'(m >> 22);
	endfunction
	assign px = trunc22(ax_q);
	assign py = trunc22(ay_q);
	logic out_map;
	assign out_map = px < 0 || px >= XLIM || py < 0 || py >= YLIM;
	assign tidx = 8'((py / TP) * MC + px / TP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b1; ph_q <= PH_ADV; n_q <= '0; kind_q <= KIND_NONE;
		end else if (cmd.finish) begin
			done_q <= 1'b0; ph_q <= PH_ADV; n_q <= '0; kind_q <= KIND_NONE;
			if (max_q == 8'd0) done_q <= 1'b1;
		end else if (cmd.step && !done_q) begin
			unique case (ph_q)
				PH_ADV: begin
					ph_q <= PH_READ;
					n_q  <= n_q + 1'b1;
				end
				PH_READ: ph_q <= PH_TEST;
				default: begin
					ph_q <= PH_ADV;
					if (out_map) begin
						done_q <= 1'b1; kind_q <= KIND_OUT; n_q <= max_q;
					end else if (wall_rd_q) begin
						done_q <= 1'b1; kind_q <= KIND_WALL;
					end else if (n_q == max_q) begin
						done_q <= 1'b1;
					end
				end
			endcase
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ax_q <= 48'(req_q.viewer_x) <<< 14;
			ay_q <= 48'(req_q.viewer_y) <<< 14;
		end else if (cmd.step && !done_q && ph_q == PH_ADV) begin
			ax_q <= nx;
			ay_q <= ny;
		end
	end

	// strip height
	logic [31:0] hq;
	logic        hd;
	logic [15:0] dd;
	always_ff @(posedge clk) d_q <= 16'(n_q) * 16'(len_q);
	assign dd = d_q;
	rmc_divider #(.N(32), .D(16)) u_hdiv (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go), .num(32'(SCREEN_ROWS * 256)), .den(dd),
		.done(hd), .quo(hq)
	);

	assign sts = '{sine_done: sine_done_q, march_done: done_q && !cmd.finish, div_done: hd};

	logic signed [33:0] top, bot;
	assign top = 34'(SCREEN_ROWS / 2) - 34'(hq >> 1);
	assign bot = 34'(SCREEN_ROWS / 2) + 34'(hq >> 1);
	always_ff @(posedge clk) begin
		if (cmd.result) begin
			res.column_out <= req_q.screen_column;
			res.hit_kind   <= kind_q;
			res.steps_taken <= n_q;
			if (d_q == 16'd0) begin
				res.strip_top    <= '0;
				res.strip_bottom <= 9'(SCREEN_ROWS - 1);
			end else begin
				res.strip_top    <= top < 0 ? 9'd0 : 9'(top);
				res.strip_bottom <= bot >= SCREEN_ROWS ? 9'(SCREEN_ROWS - 1) : 9'(bot);
			end
		end
	end
endmodule

### rtl/rmc_controller.sv
// ----------------------------------------------------------------------------
// rmc_controller
// Sequencer of one cast request: angle, sine, march, divide, result.
// ----------------------------------------------------------------------------
module rmc_controller import rmc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_cmd,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output rmc_cmd_t cmd,
	input  rmc_sts_t sts
);
	`include "ray_march_column_caster_unit_assert.svh"
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001, S_ANG  = 8'b00000010, S_SIN  = 8'b00000100,
		S_SINW = 8'b00001000, S_MAR  = 8'b00010000, S_DIV  = 8'b00100000,
		S_DIVW = 8'b01000000, S_OUT  = 8'b10000000
	} state_t;
	state_t st_q;
	logic   init_q;

	assign in_ready = (st_q == S_IDLE) && !out_valid;
	always_comb begin
		cmd = '0;
		cmd.load     = in_valid && in_ready;
		cmd.angle_go = st_q == S_ANG;
		cmd.sine_go  = st_q == S_SIN;
		cmd.finish   = st_q == S_SIN;
		cmd.step     = st_q == S_MAR;
		cmd.div_go   = st_q == S_DIV;
		cmd.result   = st_q == S_DIVW && sts.div_done;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; out_valid <= 1'b0; init_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (cmd.load && in_cmd == CMD_CAST) st_q <= S_ANG;
				S_ANG:  st_q <= S_SIN;
				S_SIN:  st_q <= S_SINW;
				S_SINW: if (sts.sine_done) st_q <= S_MAR;
				S_MAR:  if (sts.march_done) st_q <= S_DIV;
				S_DIV:  st_q <= S_DIVW;
				S_DIVW: if (sts.div_done) st_q <= S_OUT;
				S_OUT:  begin st_q <= S_IDLE; out_valid <= 1'b1; end
				default: st_q <= S_IDLE;
			endcase
			init_q <= 1'b1;
		end
	end
	`RMC_ASSERT_IMP(a_no_accept_busy, clk, arst_n, st_q != S_IDLE, !in_ready)
	`RMC_ASSERT_NEXT(a_out_after_div, clk, arst_n, cmd.result, st_q == S_OUT)
	`RMC_ASSERT_IMP(a_onehot, clk, arst_n, init_q, $onehot(st_q))
endmodule

### rtl/ray_march_column_caster_unit.sv
// ----------------------------------------------------------------------------
// ray_march_column_caster_unit
// Wall-map ray caster: one request writes a tile or casts a screen column.
// ----------------------------------------------------------------------------
// Channels: in (valid/ready, in_req_t), out (valid/ready, out_req_t) and a
// configuration write channel (cfg_valid/cfg_ready, index and data).
// A tile write returns nothing.
// A cast runs the two sine divisions, march steps up to the step limit
// (REG_MAX_STEPS) and the strip division; its length is set by the march
// loop and the bit-serial divider.
// One request is in work at a time; a new request is taken once the result
// has left the output register.
// Reset clears the wall map to open floor and loads register defaults.
// A stalled receiver holds the result; input stays not ready meanwhile.
// ----------------------------------------------------------------------------
module ray_march_column_caster_unit import rmc_pkg::*; #(
	parameter int MAP_COLUMNS    = DEF_MAP_COLUMNS,
	parameter int MAP_ROWS       = DEF_MAP_ROWS,
	parameter int TILE_PIXELS    = DEF_TILE_PIXELS,
	parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
	parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_req_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output out_req_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_req_t cfg_data
);
	rmc_cmd_t cmd;
	rmc_sts_t sts;
	assign cfg_ready = 1'b1;

	rmc_controller u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_cmd(in_data.command),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);
	rmc_datapath #(
		.MAP_COLUMNS(MAP_COLUMNS), .MAP_ROWS(MAP_ROWS), .TILE_PIXELS(TILE_PIXELS),
		.SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_ROWS(SCREEN_ROWS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .req(in_data),
		.cfg_we(cfg_valid), .cfg(cfg_data), .res(out_data)
	);
endmodule
